/* rtl/jss_pkg.sv */
// Package for the seven-point Jacobi sweep block.
// Holds the word types, register codes, controller states and command structs.
// Has no dependencies; every other file imports it.
package jss_pkg;

	localparam int MAX_GRID     = 256;
	localparam int VALUE_BITS   = 32;
	localparam int FRAC_BITS    = 24;
	localparam int CENTER_FRAC  = 40;
	localparam int GRID_W       = 9;
	localparam int ADDR_W       = 17;
	localparam int SPAN_W       = ADDR_W + 1;
	localparam int WINDOW_DEPTH = 2 * MAX_GRID * MAX_GRID;
	localparam int SUM_W        = VALUE_BITS + 3;
	localparam int RHO_W        = 42;
	localparam int MUL_M_W      = 64;
	localparam int MUL_B_W      = 48;
	localparam int MUL_DIGIT    = 8;
	localparam int MUL_STEPS    = MUL_B_W / MUL_DIGIT;
	localparam int MUL_P_W      = MUL_M_W + MUL_B_W;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_H     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_H_SQ   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CENTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EPS        = 3'd4;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic                         kind;
		logic signed [VALUE_BITS-1:0] old_value;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] new_value;
		logic                         is_last;
		logic                         converged;
		logic [VALUE_BITS-1:0]        max_error;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_M1GO,
		ST_M1WAIT,
		ST_SUB,
		ST_M2GO,
		ST_M2WAIT,
		ST_NV,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		SEL_CENTER,
		SEL_XM,
		SEL_XP,
		SEL_YM,
		SEL_YP,
		SEL_ZM
	} rd_sel_t;

	typedef struct packed {
		logic    take;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr;
		logic    mul_start;
		logic    mul_sel;
		logic    sub;
		logic    nv;
		logic    fin;
	} cmd_t;

	typedef struct packed {
		logic emit_now;
		logic write_now;
		logic emit_q;
		logic mul_done;
		logic out_free;
	} stat_t;

endpackage

/* rtl/jss_mul.sv */
// Iterative unsigned multiplier, one eight-bit digit of the second operand per cycle.
// Used by the datapath for both stencil products; depends on jss_pkg.
module jss_mul import jss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_M_W-1:0] m,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] prod,
	output logic               done
);

	logic                         busy_q;
	logic [2:0]                   cnt_q;
	logic [MUL_M_W-1:0]           m_q;
	logic [MUL_B_W-1:0]           b_q;
	logic [MUL_M_W-1:0]           acc_q;
	logic [MUL_B_W-1:0]           low_q;
	logic [MUL_M_W+MUL_DIGIT-1:0] t;

	assign t = {{MUL_DIGIT{1'b0}}, acc_q}
		+ ({{MUL_DIGIT{1'b0}}, m_q} * {{MUL_M_W{1'b0}}, b_q[MUL_DIGIT-1:0]});
	assign done = busy_q && (cnt_q == 3'(MUL_STEPS - 1));
	assign prod = {acc_q, low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= m;
			b_q   <= b;
			acc_q <= '0;
			low_q <= '0;
		end else if (busy_q) begin
			low_q <= {t[MUL_DIGIT-1:0], low_q[MUL_B_W-1:MUL_DIGIT]};
			acc_q <= t[MUL_M_W+MUL_DIGIT-1:MUL_DIGIT];
			b_q   <= b_q >> MUL_DIGIT;
		end
	end

endmodule

/* rtl/jss_dp.sv */
// Datapath: configuration registers, plane window memory, raster counters,
// stencil arithmetic and the output register. Depends on jss_pkg and jss_mul.
module jss_dp import jss_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  in_word_t              in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  out_ready,
	output logic                  out_valid,
	output out_word_t             out_data
);

	localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	logic [GRID_W-1:0]  n_q;
	logic [ADDR_W-1:0]  nn_q;
	logic [SPAN_W-1:0]  span_q;
	logic [31:0]        step_h_q;
	logic [47:0]        inv_h_sq_q;
	logic [39:0]        inv_center_q;
	logic [31:0]        eps_q;

	logic [GRID_W-1:0]  in_col_q, in_row_q, in_plane_q;
	logic [ADDR_W-1:0]  wq_q;
	logic [GRID_W-1:0]  oc_q, orow_q, opl_q;
	logic [ADDR_W-1:0]  pa_q;
	logic               all_within_q;
	logic [VALUE_BITS-1:0] worst_q;

	logic signed [VALUE_BITS-1:0] v_q;
	logic                         write_q;
	logic                         emit_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic signed [VALUE_BITS-1:0] center_q;
	logic                         rd_vld_s1;
	rd_sel_t                      rd_sel_s1;
	logic signed [VALUE_BITS-1:0] rdata_s1;
	logic [RHO_W-1:0]             r_q;
	logic                         neg_q;
	logic signed [63:0]           d_q;
	logic signed [VALUE_BITS-1:0] nv_q;
	logic                         out_valid_q;
	out_word_t                    out_q;

	logic signed [VALUE_BITS-1:0] mem [WINDOW_DEPTH];

	logic [GRID_W-1:0]  clamp_n;
	logic [GRID_W-1:0]  nm1;
	logic               last;
	logic               interior;
	logic               restart;
	logic               grid_write;
	logic [SPAN_W-1:0]  off;
	logic               off_add;
	logic [SPAN_W-1:0]  up_sum;
	logic [SPAN_W-1:0]  raddr;
	logic [MUL_M_W-1:0] mul_m;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;
	logic               mul_done;
	logic [SUM_W-1:0]   sum_abs;
	logic [63:0]        d_abs;
	logic [63:0]        q1;
	logic               rem1;
	logic signed [63:0] u;
	logic signed [63:0] d;
	logic [MUL_P_W-CENTER_FRAC-1:0] q2;
	logic               rem2;
	logic [VALUE_BITS:0] q2p;
	logic signed [VALUE_BITS-1:0] nv;
	logic signed [VALUE_BITS-1:0] nv_sel;
	logic signed [VALUE_BITS:0]   chg;
	logic [VALUE_BITS:0]          chg_abs;
	logic signed [RHO_W+1:0]      err;
	logic [RHO_W+1:0]             err_abs;
	logic [VALUE_BITS-1:0]        err_sat;
	logic                         all_next;
	logic [VALUE_BITS-1:0]        worst_next;
	logic [9:0]                   ijk;

	always_comb begin
		if (cfg_wdata[GRID_W-1:0] < GRID_W'(3)) begin
			clamp_n = GRID_W'(3);
		end else if (cfg_wdata[GRID_W-1:0] > GRID_W'(MAX_GRID)) begin
			clamp_n = GRID_W'(MAX_GRID);
		end else begin
			clamp_n = cfg_wdata[GRID_W-1:0];
		end
	end

	assign nm1        = n_q - GRID_W'(1);
	assign last       = (oc_q == nm1) && (orow_q == nm1) && (opl_q == nm1);
	assign interior   = (oc_q != '0) && (orow_q != '0) && (opl_q != '0)
		&& (oc_q != nm1) && (orow_q != nm1) && (opl_q != nm1);
	assign grid_write = cfg_we && (cfg_index == CFG_GRID_SIZE);
	assign restart    = grid_write || (cmd.fin && last);

	assign stat.write_now = (in_data.kind == KIND_DATA) && (in_plane_q < n_q);
	assign stat.emit_now  = stat.write_now ? (in_plane_q != '0) : (in_plane_q >= n_q);
	assign stat.emit_q    = emit_q;
	assign stat.mul_done  = mul_done;
	assign stat.out_free  = !out_valid_q || out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= GRID_W'(MAX_GRID);
			nn_q         <= ADDR_W'(MAX_GRID * MAX_GRID);
			span_q       <= SPAN_W'(WINDOW_DEPTH);
			step_h_q     <= 32'd131072;
			inv_h_sq_q   <= 48'd274877906944;
			inv_center_q <= 40'd11184925;
			eps_q        <= 32'd168;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_SIZE: begin
					n_q    <= clamp_n;
					nn_q   <= ADDR_W'(clamp_n) * ADDR_W'(clamp_n);
					span_q <= {ADDR_W'(clamp_n) * ADDR_W'(clamp_n), 1'b0};
				end
				CFG_STEP_H:     step_h_q     <= cfg_wdata[31:0];
				CFG_INV_H_SQ:   inv_h_sq_q   <= cfg_wdata[47:0];
				CFG_INV_CENTER: inv_center_q <= cfg_wdata[39:0];
				CFG_EPS:        eps_q        <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// Neighbor addresses within the circular window.
	always_comb begin
		unique case (cmd.rd_sel)
			SEL_CENTER: begin off = '0;                off_add = 1'b1; end
			SEL_XM:     begin off = SPAN_W'(1);        off_add = 1'b0; end
			SEL_XP:     begin off = SPAN_W'(1);        off_add = 1'b1; end
			SEL_YM:     begin off = SPAN_W'(n_q);      off_add = 1'b0; end
			SEL_YP:     begin off = SPAN_W'(n_q);      off_add = 1'b1; end
			SEL_ZM:     begin off = SPAN_W'(nn_q);     off_add = 1'b0; end
			default:    begin off = '0;                off_add = 1'b1; end
		endcase
		up_sum = SPAN_W'(pa_q) + off;
		if (off_add) begin
			raddr = (up_sum >= span_q) ? up_sum - span_q : up_sum;
		end else begin
			raddr = (SPAN_W'(pa_q) >= off) ? SPAN_W'(pa_q) - off
				: SPAN_W'(pa_q) + span_q - off;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && write_q) begin
			mem[wq_q] <= v_q;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[raddr[ADDR_W-1:0]];
		end
	end

	// Input raster counters and read pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_plane_q <= '0;
			wq_q       <= '0;
			write_q    <= 1'b0;
			emit_q     <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_sel_s1  <= SEL_CENTER;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			rd_sel_s1 <= cmd.rd_sel;
			if (cmd.take) begin
				write_q <= stat.write_now;
				emit_q  <= stat.emit_now;
			end
			if (restart) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_plane_q <= '0;
				wq_q       <= '0;
			end else if (cmd.wr && write_q) begin
				wq_q <= (SPAN_W'(wq_q) + SPAN_W'(1) == span_q) ? '0 : wq_q + ADDR_W'(1);
				if (in_col_q == nm1) begin
					in_col_q <= '0;
					if (in_row_q == nm1) begin
						in_row_q   <= '0;
						in_plane_q <= in_plane_q + GRID_W'(1);
					end else begin
						in_row_q <= in_row_q + GRID_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + GRID_W'(1);
				end
			end
		end
	end

	// Stencil arithmetic.
	assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign d_abs   = d_q[63] ? 64'(-d_q) : 64'(d_q);
	assign mul_m   = cmd.mul_sel ? d_abs : MUL_M_W'(sum_abs);
	assign mul_b   = cmd.mul_sel ? MUL_B_W'(inv_center_q) : inv_h_sq_q;
	assign ijk     = 10'(oc_q) + 10'(orow_q) + 10'(opl_q);

	jss_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.m      (mul_m),
		.b      (mul_b),
		.prod   (prod),
		.done   (mul_done)
	);

	always_comb begin
		q1   = prod[FRAC_BITS+63:FRAC_BITS];
		rem1 = |prod[FRAC_BITS-1:0];
		u    = neg_q ? -$signed(q1 + 64'(rem1)) : $signed(q1);
		d    = u - $signed({22'b0, r_q});

		q2   = prod[MUL_P_W-1:CENTER_FRAC];
		rem2 = |prod[CENTER_FRAC-1:0];
		q2p  = {1'b0, q2[VALUE_BITS-1:0]} + (VALUE_BITS+1)'(rem2);
		if (!neg_q) begin
			nv = (q2 > (MUL_P_W-CENTER_FRAC)'(VMAX)) ? VMAX : q2[VALUE_BITS-1:0];
		end else if (q2 >= (MUL_P_W-CENTER_FRAC)'({1'b0, VMIN})) begin
			nv = VMIN;
		end else if (q2p >= {1'b0, VMIN}) begin
			nv = VMIN;
		end else begin
			nv = -$signed(q2p[VALUE_BITS-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			v_q   <= in_data.old_value;
			sum_q <= stat.write_now ? SUM_W'(in_data.old_value) : '0;
		end else if (rd_vld_s1) begin
			if (rd_sel_s1 == SEL_CENTER) begin
				center_q <= rdata_s1;
			end else begin
				sum_q <= sum_q + SUM_W'(rdata_s1);
			end
		end
		if (cmd.mul_start) begin
			neg_q <= cmd.mul_sel ? d_q[63] : sum_q[SUM_W-1];
			if (!cmd.mul_sel) begin
				r_q <= RHO_W'(ijk) * RHO_W'(step_h_q);
			end
		end
		if (cmd.sub) begin
			d_q <= d;
		end
		if (cmd.nv) begin
			nv_q <= nv;
		end
	end

	// Result, error tracking and output counters.
	always_comb begin
		nv_sel  = interior ? nv_q : center_q;
		chg     = (VALUE_BITS+1)'(nv_q) - (VALUE_BITS+1)'(center_q);
		chg_abs = chg[VALUE_BITS] ? (VALUE_BITS+1)'(-chg) : (VALUE_BITS+1)'(chg);
		err     = (RHO_W+2)'(nv_q) - $signed({2'b0, r_q});
		err_abs = err[RHO_W+1] ? (RHO_W+2)'(-err) : (RHO_W+2)'(err);
		err_sat = (|err_abs[RHO_W+1:VALUE_BITS]) ? '1 : err_abs[VALUE_BITS-1:0];
		all_next   = all_within_q && !(interior && (chg_abs > (VALUE_BITS+1)'(eps_q)));
		worst_next = (interior && (err_sat > worst_q)) ? err_sat : worst_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q         <= '0;
			orow_q       <= '0;
			opl_q        <= '0;
			pa_q         <= '0;
			all_within_q <= 1'b1;
			worst_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (restart) begin
				oc_q         <= '0;
				orow_q       <= '0;
				opl_q        <= '0;
				pa_q         <= '0;
				all_within_q <= 1'b1;
				worst_q      <= '0;
			end else if (cmd.fin) begin
				all_within_q <= all_next;
				worst_q      <= worst_next;
				pa_q <= (SPAN_W'(pa_q) + SPAN_W'(1) == span_q) ? '0 : pa_q + ADDR_W'(1);
				if (oc_q == nm1) begin
					oc_q <= '0;
					if (orow_q == nm1) begin
						orow_q <= '0;
						opl_q  <= opl_q + GRID_W'(1);
					end else begin
						orow_q <= orow_q + GRID_W'(1);
					end
				end else begin
					oc_q <= oc_q + GRID_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.new_value <= nv_sel;
			out_q.is_last   <= last;
			out_q.converged <= last && all_next;
			out_q.max_error <= worst_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/jss_ctrl.sv */
// Controller state machine that sequences window reads, the write, both
// multiplications and the result hand-off. Depends on jss_pkg.
module jss_ctrl import jss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t     state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.rd_sel = SEL_CENTER;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					cnt_d    = '0;
					if (stat.emit_now) begin
						state_d = ST_READ;
					end else if (stat.write_now) begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rd_sel_t'(cnt_q);
				cnt_d      = cnt_q + 3'd1;
				if (rd_sel_t'(cnt_q) == SEL_ZM) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = stat.emit_q ? ST_M1GO : ST_IDLE;
			end
			ST_M1GO: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_M1WAIT;
			end
			ST_M1WAIT: begin
				if (stat.mul_done) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = ST_M2GO;
			end
			ST_M2GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = 1'b1;
				state_d       = ST_M2WAIT;
			end
			ST_M2WAIT: begin
				cmd.mul_sel = 1'b1;
				if (stat.mul_done) begin
					state_d = ST_NV;
				end
			end
			ST_NV: begin
				cmd.nv  = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/jacobi_stencil_sweep_3d.sv */
// Top level of the seven-point Jacobi sweep over a cubic grid.
// Joins the controller jss_ctrl and the datapath jss_dp; depends on jss_pkg.
//
//   channel  | handshake           | word
//   ---------+---------------------+--------------------------------------------
//   input    | in_valid / in_ready | in_data: kind, old_value
//   output   | out_valid/out_ready | out_data: new_value, is_last, converged,
//            |                     |           max_error
//   config   | cfg_we              | cfg_index, cfg_wdata
//
// A word that finishes a point passes through six window reads on the single
// read port, the write, two six-step multiplications and the result stage.
// A word that only fills the window goes to the write state; an ignored flush stays idle.
// Reset clears the counters and flags; the window needs no clearing pass.
// A full output register stalls the block in its result stage.
module jacobi_stencil_sweep_3d import jss_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	jss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	jss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

/* rtl/jss_checker.sv */
// Port-level checker for the Jacobi sweep block, bound to the top level.
// Depends on jss_pkg and jacobi_stencil_sweep_3d.
module jss_checker import jss_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input in_word_t              in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input out_word_t             out_data,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Output word changed while stalled.");

	a_conv_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.converged |-> out_data.is_last)
		else $error("Converged flag set on a word that is not the last.");

	a_busy_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("Result appeared without the block having been busy.");

endmodule

bind jacobi_stencil_sweep_3d jss_checker u_jss_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for the seven-point Jacobi sweep block.
// Drives grid sweeps through the valid/ready channels and checks every result
// against an in-line predictor. Depends on jss_pkg and jacobi_stencil_sweep_3d.
module testbench;
	import jss_pkg::*;

	localparam int LIMIT = 4000;
	localparam int SETTLE = 60;

	typedef struct {
		bit       pause;
		in_word_t w;
	} stim_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	stim_t     pending_words[$];
	out_word_t expected_points[$];

	longint window_mem [0:WINDOW_DEPTH-1];
	longint unsigned col_cnt, row_cnt, plane_cnt, next_out;
	bit within_eps;
	longint unsigned worst_err;
	logic [8:0]  r_grid;
	logic [31:0] r_step;
	logic [47:0] r_ihsq;
	logic [39:0] r_icen;
	logic [31:0] r_eps;

	int n_errors, n_results, n_words, n_sweeps, idle_cycles;
	int send_gap, recv_gap, hold_cnt;
	bit send_calm, recv_calm, held;

	jacobi_stencil_sweep_3d i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned grid_edge();
		longint unsigned g = r_grid;
		if (g < 3) g = 3;
		if (g > MAX_GRID) g = MAX_GRID;
		return g;
	endfunction

	function automatic longint scaled_floor(longint a, logic [47:0] b, int sh,
			longint lo, longint hi);
		logic signed [127:0] pa, pb, p;
		pa = a;
		pb = $signed({80'd0, b});
		p = (pa * pb) >>> sh;
		if (p > hi) return hi;
		if (p < lo) return lo;
		return p[63:0];
	endfunction

	function automatic longint unsigned abs_gap(longint a, longint b);
		logic signed [127:0] t;
		t = a;
		t = t - b;
		if (t < 0) t = -t;
		return t[63:0];
	endfunction

	task automatic restart_sweep();
		col_cnt = 0; row_cnt = 0; plane_cnt = 0; next_out = 0;
		within_eps = 1'b1;
		worst_err = 0;
	endtask

	task automatic finish_point(longint unsigned p, longint up);
		longint unsigned n, nn, spn, i, j, k, err;
		longint center, nv, s, r, u, d;
		logic signed [127:0] t;
		bit last;
		out_word_t o;
		n = grid_edge(); nn = n * n; spn = 2 * nn;
		i = p % n; j = (p / n) % n; k = p / nn;
		center = window_mem[p % spn];
		nv = center;
		last = (p == nn * n - 1);
		if (i != 0 && j != 0 && k != 0 && i != n - 1 && j != n - 1 && k != n - 1) begin
			s = window_mem[(p - 1) % spn] + window_mem[(p + 1) % spn]
				+ window_mem[(p - n) % spn] + window_mem[(p + n) % spn]
				+ window_mem[(p - nn) % spn] + up;
			r = (i + j + k) * longint'(r_step);
			u = scaled_floor(s, r_ihsq, FRAC_BITS, 64'sh8000000000000000,
				64'sh7FFFFFFFFFFFFFFF);
			t = u;
			t = t - r;
			if (t > 64'sh7FFFFFFFFFFFFFFF) d = 64'sh7FFFFFFFFFFFFFFF;
			else if (t < -128'sh8000000000000000) d = 64'sh8000000000000000;
			else d = t[63:0];
			nv = scaled_floor(d, {8'd0, r_icen}, CENTER_FRAC, -64'sd2147483648,
				64'sd2147483647);
			if (abs_gap(nv, center) > r_eps) within_eps = 1'b0;
			err = abs_gap(nv, r);
			if (err > 64'hFFFFFFFF) err = 64'hFFFFFFFF;
			if (err > worst_err) worst_err = err;
		end
		o.new_value = nv[31:0];
		o.is_last = last;
		o.converged = last && within_eps;
		o.max_error = worst_err[31:0];
		expected_points.push_back(o);
		next_out = p + 1;
		if (last) begin
			n_sweeps++;
			restart_sweep();
		end
	endtask

	task automatic predict_word(in_word_t w);
		longint unsigned n, nn, total, spn, q, p;
		longint v;
		n = grid_edge(); nn = n * n; total = nn * n; spn = 2 * nn;
		q = (plane_cnt * n + row_cnt) * n + col_cnt;
		if (w.kind == KIND_DATA && q < total) begin
			v = w.old_value;
			if (q >= nn) finish_point(q - nn, v);
			window_mem[q % spn] = v;
			col_cnt++;
			if (col_cnt >= n) begin
				col_cnt = 0;
				row_cnt++;
				if (row_cnt >= n) begin
					row_cnt = 0;
					plane_cnt++;
				end
			end
		end else if (q >= total && next_out < total) begin
			p = next_out;
			if (p + nn < total) p = total - nn;
			finish_point(p, 0);
		end
	endtask

	task automatic report(string field, longint unsigned want, longint unsigned got);
		n_errors++;
		if (n_errors <= 20)
			$display("mismatch on result %0d, %s: expected %h, got %h",
				n_results, field, want, got);
	endtask

	function automatic int draw_wait(bit calm);
		if (calm || $urandom_range(0, 2) != 0) return 0;
		return $urandom_range(0, 12);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
			send_calm <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_word(in_data);
				n_words++;
			end
			if ($urandom_range(0, 99) == 0) send_calm <= ~send_calm;
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 && pending_words[0].pause) begin
					in_valid <= 1'b0;
					if (expected_points.size() == 0) void'(pending_words.pop_front());
				end else if (pending_words.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_words.pop_front().w;
					send_gap <= draw_wait(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			hold_cnt <= 0;
			held <= 1'b0;
			recv_calm <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					report("unexpected result", 0, out_data);
				end else begin
					out_word_t e;
					e = expected_points.pop_front();
					if (out_data.new_value !== e.new_value)
						report("new_value", e.new_value, out_data.new_value);
					if (out_data.is_last !== e.is_last)
						report("is_last", e.is_last, out_data.is_last);
					if (out_data.converged !== e.converged)
						report("converged", e.converged, out_data.converged);
					if (out_data.max_error !== e.max_error)
						report("max_error", e.max_error, out_data.max_error);
				end
				n_results++;
			end
			if ($urandom_range(0, 99) == 0) recv_calm <= ~recv_calm;
			if (!held && n_results == 200) begin
				held <= 1'b1;
				hold_cnt <= 400;
				out_ready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				recv_gap <= draw_wait(recv_calm);
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("timeout after %0d cycles without progress", LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_GRID_SIZE: begin
				r_grid = val[8:0];
				restart_sweep();
			end
			CFG_STEP_H: r_step = val[31:0];
			CFG_INV_H_SQ: r_ihsq = val[47:0];
			CFG_INV_CENTER: r_icen = val[39:0];
			CFG_EPS: r_eps = val[31:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_word(logic kind, logic [31:0] v);
		stim_t s;
		s.pause = 1'b0;
		s.w.kind = kind;
		s.w.old_value = v;
		pending_words.push_back(s);
	endtask

	function automatic logic [31:0] draw_value(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 1 << 26) - (1 << 25);
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 32'h0;
					3: return 32'hFFFFFFFF;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	function automatic logic [47:0] draw_wide(int bits);
		logic [47:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			default: ;
		endcase
		return v & ((48'd1 << bits) - 1);
	endfunction

	initial begin
		int n, mode, queued, pos;
		stim_t pause_word;
		r_grid = 9'd256; r_step = 32'd131072; r_ihsq = 48'd274877906944;
		r_icen = 40'd11184925; r_eps = 32'd168;
		restart_sweep();
		pause_word.pause = 1'b1;
		pause_word.w = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset size: a few words that fill the window, then an early flush.
		queue_word(KIND_DATA, 32'h7FFFFFFF);
		queue_word(KIND_DATA, 32'h80000000);
		queue_word(KIND_DATA, 32'h0);
		queue_word(KIND_DATA, 32'hFFFFFFFF);
		queue_word(KIND_FLUSH, 32'h5A5A5A5A);
		wait_drained();
		write_reg(CFG_GRID_SIZE, 48'd511);
		write_reg(3'd7, 48'hFFFF);
		end_writes();
		queue_word(KIND_DATA, 32'h12345678);
		queue_word(KIND_FLUSH, 32'h0);
		wait_drained();

		queued = 0;
		while (queued < 1900) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 7) : $urandom_range(3, 5);
			if (n == 3 && $urandom_range(0, 1)) write_reg(CFG_GRID_SIZE, $urandom_range(0, 3));
			else write_reg(CFG_GRID_SIZE, n);
			if ($urandom_range(0, 2) == 0) begin
				write_reg(CFG_STEP_H, draw_wide(32));
				write_reg(CFG_INV_H_SQ, draw_wide(48));
				write_reg(CFG_INV_CENTER, draw_wide(40));
				write_reg(CFG_EPS, draw_wide(32));
			end else if ($urandom_range(0, 1)) begin
				write_reg(CFG_STEP_H, 48'd131072);
				write_reg(CFG_INV_H_SQ, 48'd274877906944);
				write_reg(CFG_INV_CENTER, 48'd11184925);
				write_reg(CFG_EPS, $urandom_range(0, 1) ? 48'hFFFFFFFF : 48'd168);
			end
			end_writes();
			mode = $urandom_range(0, 2);
			pos = $urandom_range(0, 4 * n * n * n);
			for (int q = 0; q < n * n * n; q++) begin
				if (q == pos) pending_words.push_back(pause_word);
				if ($urandom_range(0, 40) == 0) queue_word(KIND_FLUSH, $urandom);
				queue_word(KIND_DATA, draw_value(mode));
			end
			for (int q = 0; q < n * n; q++)
				queue_word($urandom_range(0, 7) == 0 ? KIND_DATA : KIND_FLUSH, $urandom);
			for (int q = $urandom_range(0, 2); q > 0; q--) queue_word(KIND_FLUSH, $urandom);
			queued += n * n * n + n * n;
			wait_drained();
		end

		$display("Covered %0d words and %0d results over %0d complete sweeps,", n_words,
			n_results, n_sweeps);
		$display("with edge sizes 3 to 7, clamped sizes and register extremes.");
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
